>>> rtl/cmds_pkg.sv
// ----------------------------------------------------------------------------
// cmds_pkg
// Types, constants and helpers shared by the ratio search controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package cmds_pkg;

  localparam int T_W     = 18;  // target frequency, kHz
  localparam int CNT_W   = 8;   // multiplier / divider counters
  localparam int DT_W    = 25;  // d * T, at most 128 * (2^18 - 1)
  localparam int ERR_W   = 25;  // |10000*m - d*T|
  localparam int PROD_W  = ERR_W + CNT_W;
  localparam int ADDR_W  = 7;
  localparam int WORD_W  = 16;

  localparam logic [DT_W-1:0]  RATIO_DEN   = DT_W'(10000);
  localparam logic [DT_W-1:0]  INIT_M10K   = DT_W'(20000);  // 10000 * first m
  localparam logic [CNT_W-1:0] FIRST_MULT  = CNT_W'(2);
  localparam logic [CNT_W-1:0] FIRST_DIV   = CNT_W'(1);

  localparam logic [WORD_W-1:0] NO_COUNT_BIT = 16'h1000;
  localparam logic [WORD_W-1:0] OUT0_WORD    = 16'h1145;  // count 5/5
  localparam logic [WORD_W-1:0] OUT1_WORD    = 16'h1041;  // count 1/1

  localparam logic [ADDR_W-1:0] ADDR_FB     = 7'h14;
  localparam logic [ADDR_W-1:0] ADDR_DIVCLK = 7'h16;
  localparam logic [ADDR_W-1:0] ADDR_OUT0   = 7'h08;
  localparam logic [ADDR_W-1:0] ADDR_OUT1   = 7'h0a;

  // write sequence slots
  localparam logic [1:0] WR_FB     = 2'd0;
  localparam logic [1:0] WR_DIVCLK = 2'd1;
  localparam logic [1:0] WR_OUT0   = 2'd2;
  localparam logic [1:0] WR_OUT1   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic       load;    // capture target, restart search
    logic       step;    // issue next candidate
    logic       emit;    // drive one config write
    logic [1:0] wr_idx;  // which write
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_cand;     // counters sit on the final (m, d) pair
  } dp_status_t;

  // high/low count pair, each in a 6-bit field; a count of 64 wraps to 0
  function automatic logic [11:0] count_word(input logic [CNT_W-1:0] n);
    logic [6:0] hi;
    logic [6:0] lo;
    hi = n[CNT_W-1:1];
    lo = hi + {6'd0, n[0]};
    return {hi[5:0], lo[5:0]};
  endfunction

endpackage

>>> rtl/cmds_ctrl.sv
// ----------------------------------------------------------------------------
// cmds_ctrl
// Sequencer: idle, candidate sweep, pipeline drain, four config writes.
// ----------------------------------------------------------------------------
module cmds_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  cmds_pkg::dp_status_t  status,
  output cmds_pkg::ctrl_cmd_t   cmd,
  output logic                  busy
);

  cmds_pkg::state_t state_r, state_nxt;
  logic [1:0]       wr_idx_r, wr_idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cmds_pkg::ST_IDLE;
      wr_idx_r <= cmds_pkg::WR_FB;
    end else begin
      state_r  <= state_nxt;
      wr_idx_r <= wr_idx_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    wr_idx_nxt  = wr_idx_r;
    cmd.load    = 1'b0;
    cmd.step    = 1'b0;
    cmd.emit    = 1'b0;
    cmd.wr_idx  = wr_idx_r;
    busy        = 1'b1;
    case (state_r)
      cmds_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = cmds_pkg::ST_SEARCH;
        end
      end
      cmds_pkg::ST_SEARCH: begin
        cmd.step = 1'b1;
        if (status.last_cand) begin
          state_nxt = cmds_pkg::ST_DRAIN;
        end
      end
      // last candidate is being compared this cycle
      cmds_pkg::ST_DRAIN: begin
        wr_idx_nxt = cmds_pkg::WR_FB;
        state_nxt  = cmds_pkg::ST_WRITE;
      end
      cmds_pkg::ST_WRITE: begin
        cmd.emit = 1'b1;
        if (wr_idx_r == cmds_pkg::WR_OUT1) begin
          wr_idx_nxt = cmds_pkg::WR_FB;
          state_nxt  = cmds_pkg::ST_IDLE;
        end else begin
          wr_idx_nxt = wr_idx_r + 2'd1;
        end
      end
      default: begin
        state_nxt  = cmds_pkg::ST_IDLE;
        wr_idx_nxt = cmds_pkg::WR_FB;
      end
    endcase
  end

endmodule

>>> rtl/cmds_dp.sv
// ----------------------------------------------------------------------------
// cmds_dp
// Candidate counters, error stage, cross-multiply compare, best pair and
// config write output registers.
// ----------------------------------------------------------------------------
module cmds_dp #(
  parameter int MAX_MULT = 128,
  parameter int MAX_DIV  = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmds_pkg::ctrl_cmd_t           cmd,
  input  logic [cmds_pkg::T_W-1:0]      target_khz,
  output cmds_pkg::dp_status_t          status,
  output logic                          out_valid,
  output logic [cmds_pkg::CNT_W-1:0]    out_mult,
  output logic [cmds_pkg::CNT_W-1:0]    out_div,
  output logic [cmds_pkg::ADDR_W-1:0]   out_addr,
  output logic [cmds_pkg::WORD_W-1:0]   out_word,
  output logic                          out_last
);

  localparam int CW = cmds_pkg::CNT_W;
  localparam int DW = cmds_pkg::DT_W;
  localparam int EW = cmds_pkg::ERR_W;
  localparam int PW = cmds_pkg::PROD_W;
  localparam logic [CW-1:0] MAX_M = CW'(MAX_MULT);
  localparam logic [CW-1:0] MAX_D = CW'(MAX_DIV);

  // candidate generation
  logic [cmds_pkg::T_W-1:0] t_r;
  logic [CW-1:0]            m_r, d_r;
  logic [DW-1:0]            dt_r;    // d * T
  logic [DW-1:0]            m10k_r;  // 10000 * m

  // compare stage
  logic          v1_r;
  logic [CW-1:0] m_s1_r, d_s1_r;
  logic [EW-1:0] em_s1_r;

  // best so far
  logic [CW-1:0] bm_r, bd_r;
  logic [EW-1:0] eb_r;

  logic [EW-1:0] em_nxt;
  logic [EW-1:0] eb_init;
  logic [DW-1:0] t_ext;
  logic [PW-1:0] cur_prod, tst_prod;
  logic          upd;

  logic [cmds_pkg::ADDR_W-1:0] addr_nxt;
  logic [cmds_pkg::WORD_W-1:0] word_nxt;

  assign t_ext            = DW'(target_khz);
  assign status.last_cand = (m_r == MAX_M) && (d_r == MAX_D);

  assign em_nxt  = (m10k_r >= dt_r) ? EW'(m10k_r - dt_r) : EW'(dt_r - m10k_r);
  assign eb_init = (cmds_pkg::INIT_M10K >= t_ext) ? EW'(cmds_pkg::INIT_M10K - t_ext)
                                                  : EW'(t_ext - cmds_pkg::INIT_M10K);

  // d * |10000*bm - bd*T|  vs  bd * |10000*m - d*T|
  assign cur_prod = PW'(d_s1_r) * PW'(eb_r);
  assign tst_prod = PW'(bd_r) * PW'(em_s1_r);
  assign upd      = v1_r && (tst_prod < cur_prod);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= cmds_pkg::FIRST_MULT;
      d_r <= cmds_pkg::FIRST_DIV;
    end else if (cmd.load) begin
      t_r    <= target_khz;
      m_r    <= cmds_pkg::FIRST_MULT;
      d_r    <= cmds_pkg::FIRST_DIV;
      dt_r   <= t_ext;
      m10k_r <= cmds_pkg::INIT_M10K;
    end else if (cmd.step) begin
      if (m_r == MAX_M) begin
        m_r    <= cmds_pkg::FIRST_MULT;
        m10k_r <= cmds_pkg::INIT_M10K;
        if (d_r == MAX_D) begin
          d_r  <= cmds_pkg::FIRST_DIV;
          dt_r <= DW'(t_r);
        end else begin
          d_r  <= d_r + CW'(1);
          dt_r <= dt_r + DW'(t_r);
        end
      end else begin
        m_r    <= m_r + CW'(1);
        m10k_r <= m10k_r + cmds_pkg::RATIO_DEN;
      end
    end
    if (cmd.step) begin
      m_s1_r  <= m_r;
      d_s1_r  <= d_r;
      em_s1_r <= em_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      bm_r <= cmds_pkg::FIRST_MULT;
      bd_r <= cmds_pkg::FIRST_DIV;
      eb_r <= '0;
    end else begin
      v1_r <= cmd.step;
      if (cmd.load) begin
        bm_r <= cmds_pkg::FIRST_MULT;
        bd_r <= cmds_pkg::FIRST_DIV;
        eb_r <= eb_init;
      end else if (upd) begin
        bm_r <= m_s1_r;
        bd_r <= d_s1_r;
        eb_r <= em_s1_r;
      end
    end
  end

  always_comb begin
    case (cmd.wr_idx)
      cmds_pkg::WR_FB: begin
        addr_nxt = cmds_pkg::ADDR_FB;
        word_nxt = cmds_pkg::NO_COUNT_BIT | {4'd0, cmds_pkg::count_word(bm_r)};
      end
      cmds_pkg::WR_DIVCLK: begin
        addr_nxt = cmds_pkg::ADDR_DIVCLK;
        word_nxt = (bd_r == cmds_pkg::FIRST_DIV) ? cmds_pkg::NO_COUNT_BIT
                                                 : {4'd0, cmds_pkg::count_word(bd_r)};
      end
      cmds_pkg::WR_OUT0: begin
        addr_nxt = cmds_pkg::ADDR_OUT0;
        word_nxt = cmds_pkg::OUT0_WORD;
      end
      cmds_pkg::WR_OUT1: begin
        addr_nxt = cmds_pkg::ADDR_OUT1;
        word_nxt = cmds_pkg::OUT1_WORD;
      end
      default: begin
        addr_nxt = cmds_pkg::ADDR_FB;
        word_nxt = cmds_pkg::NO_COUNT_BIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
    if (cmd.emit) begin
      out_mult <= bm_r;
      out_div  <= bd_r;
      out_addr <= addr_nxt;
      out_word <= word_nxt;
      out_last <= (cmd.wr_idx == cmds_pkg::WR_OUT1);
    end
  end

`ifndef SYNTHESIS
  a_load_init: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (bm_r == cmds_pkg::FIRST_MULT && bd_r == cmds_pkg::FIRST_DIV))
    else $error("best pair not restarted on load");

  // sweep order makes the divider of a new best never smaller
  a_upd_order: assert property (@(posedge clk) disable iff (!rst_n)
    upd |-> (d_s1_r >= bd_r))
    else $error("best pair replaced by an earlier divider");

  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && status.last_cand) |=>
      (m_r == cmds_pkg::FIRST_MULT && d_r == cmds_pkg::FIRST_DIV))
    else $error("counters not back at first pair after sweep");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("write strobe right after final write");
`endif

endmodule

>>> rtl/clock_mult_div_search_core.sv
// ----------------------------------------------------------------------------
// clock_mult_div_search_core
// Multiplier/divider ratio search for a clock tile and its four config writes.
// ----------------------------------------------------------------------------
// Operation: the sweep feeds one candidate per cycle through the
//   cross-multiply compare and then passes a drain state; the four writes
//   follow on consecutive cycles.
// Handshake: start is taken only in idle; busy stays high until the last
//   write is issued. The receiver cannot stall.
// Reset: synchronous active-low; returns idle, best pair m=2, d=1.
module clock_mult_div_search_core #(
  parameter int MAX_MULT = 128,
  parameter int MAX_DIV  = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [cmds_pkg::T_W-1:0]         in_target_khz,
  output logic                             out_strobe,
  output logic [cmds_pkg::CNT_W-1:0]       out_best_mult,
  output logic [cmds_pkg::CNT_W-1:0]       out_best_div,
  output logic [cmds_pkg::ADDR_W-1:0]      out_cfg_address,
  output logic [cmds_pkg::WORD_W-1:0]      out_cfg_word,
  output logic                             out_last_write
);

  cmds_pkg::ctrl_cmd_t  cmd;
  cmds_pkg::dp_status_t status;

  cmds_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  cmds_dp #(
    .MAX_MULT (MAX_MULT),
    .MAX_DIV  (MAX_DIV)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .target_khz (in_target_khz),
    .status     (status),
    .out_valid  (out_strobe),
    .out_mult   (out_best_mult),
    .out_div    (out_best_div),
    .out_addr   (out_cfg_address),
    .out_word   (out_cfg_word),
    .out_last   (out_last_write)
  );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the clock multiplier/divider ratio search core.
// A short table of targets (zero, full scale, exact ratios, counts of 64)
// runs first. Random targets across the whole 18-bit field follow. Every item
// is checked against a local exhaustive search, or against typed-in values
// for the obvious rows. Each of the four config writes is compared field by
// field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_MULT      = 128;
  localparam int MAX_DIV       = 128;
  localparam int SEARCH_CYCLES = (MAX_MULT - 1) * MAX_DIV + 6;
  localparam int RANDOM_ITEMS  = 80;
  localparam int CYCLE_LIMIT   = 4 * 110 * (SEARCH_CYCLES + 20);

  typedef struct {
    logic [cmds_pkg::T_W-1:0]    target;
    bit                          typed;
    logic [cmds_pkg::CNT_W-1:0]  mult;
    logic [cmds_pkg::CNT_W-1:0]  div;
    logic [cmds_pkg::WORD_W-1:0] fb_word;
    logic [cmds_pkg::WORD_W-1:0] div_word;
  } target_row_t;

  typedef struct {
    logic [cmds_pkg::CNT_W-1:0]  mult;
    logic [cmds_pkg::CNT_W-1:0]  div;
    logic [cmds_pkg::ADDR_W-1:0] addr;
    logic [cmds_pkg::WORD_W-1:0] word;
    logic                        last;
  } cfg_write_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [cmds_pkg::T_W-1:0]      in_target_khz;
  logic                          out_strobe;
  logic [cmds_pkg::CNT_W-1:0]    out_best_mult;
  logic [cmds_pkg::CNT_W-1:0]    out_best_div;
  logic [cmds_pkg::ADDR_W-1:0]   out_cfg_address;
  logic [cmds_pkg::WORD_W-1:0]   out_cfg_word;
  logic                          out_last_write;

  cfg_write_t  pending_writes[$];
  cfg_write_t  head_write;
  target_row_t target_rows[];
  int          err_count    = 0;
  int          writes_seen  = 0;
  int          items_sent   = 0;
  int          cycle_count  = 0;
  bit          gaps_on      = 1'b1;

  clock_mult_div_search_core #(
    .MAX_MULT(MAX_MULT),
    .MAX_DIV (MAX_DIV)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_target_khz  (in_target_khz),
    .out_strobe     (out_strobe),
    .out_best_mult  (out_best_mult),
    .out_best_div   (out_best_div),
    .out_cfg_address(out_cfg_address),
    .out_cfg_word   (out_cfg_word),
    .out_last_write (out_last_write)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d writes still pending", $time,
               cycle_count, pending_writes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // hi = n/2, lo = n/2 + odd bit; each kept to 6 bits so 64 reads as 0
  function automatic logic [11:0] half_counts(input logic [cmds_pkg::CNT_W-1:0] n);
    logic [6:0] hi;
    logic [6:0] lo;
    hi = n[cmds_pkg::CNT_W-1:1];
    lo = hi + {6'd0, n[0]};
    return {hi[5:0], lo[5:0]};
  endfunction

  task automatic queue_writes(input logic [cmds_pkg::CNT_W-1:0] m,
                              input logic [cmds_pkg::CNT_W-1:0] d,
                              input logic [cmds_pkg::WORD_W-1:0] fb_word,
                              input logic [cmds_pkg::WORD_W-1:0] div_word);
    pending_writes.push_back('{m, d, cmds_pkg::ADDR_FB,     fb_word,             1'b0});
    pending_writes.push_back('{m, d, cmds_pkg::ADDR_DIVCLK, div_word,            1'b0});
    pending_writes.push_back('{m, d, cmds_pkg::ADDR_OUT0,   cmds_pkg::OUT0_WORD, 1'b0});
    pending_writes.push_back('{m, d, cmds_pkg::ADDR_OUT1,   cmds_pkg::OUT1_WORD, 1'b1});
  endtask

  // Exhaustive search for m/d closest to target/10000; earlier pair wins ties.
  task automatic predict_writes(input logic [cmds_pkg::T_W-1:0] target);
    longint                      t;
    longint                      bm;
    longint                      bd;
    longint                      cur_err;
    longint                      cand_err;
    logic [cmds_pkg::CNT_W-1:0]  m8;
    logic [cmds_pkg::CNT_W-1:0]  d8;
    logic [cmds_pkg::WORD_W-1:0] dv_word;
    t  = longint'(target);
    bm = 2;
    bd = 1;
    for (longint d = 1; d <= MAX_DIV; d++) begin
      for (longint m = 2; m <= MAX_MULT; m++) begin
        cur_err  = d  * magnitude(longint'(cmds_pkg::RATIO_DEN) * bm - bd * t);
        cand_err = bd * magnitude(longint'(cmds_pkg::RATIO_DEN) * m  - d  * t);
        if (cand_err < cur_err) begin
          bm = m;
          bd = d;
        end
      end
    end
    m8 = cmds_pkg::CNT_W'(bm);
    d8 = cmds_pkg::CNT_W'(bd);
    dv_word = (d8 == cmds_pkg::FIRST_DIV) ? cmds_pkg::NO_COUNT_BIT
                                          : {4'h0, half_counts(d8)};
    queue_writes(m8, d8, cmds_pkg::NO_COUNT_BIT | {4'h0, half_counts(m8)}, dv_word);
  endtask

  task automatic check_field(input string name, input logic [cmds_pkg::WORD_W-1:0] exp_val,
                             input logic [cmds_pkg::WORD_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_val, act_val);
      err_count++;
    end
  endtask

  // Start toggles at random while the core is busy, so idle cycles also land
  // on the cycle where busy drops. The target bus carries junk when start is low.
  task automatic send_target(input logic [cmds_pkg::T_W-1:0] target);
    logic go;
    do begin
      go = !gaps_on || ($urandom_range(99, 0) >= 35);
      start         <= go;
      in_target_khz <= go ? target : cmds_pkg::T_W'($urandom);
      @(posedge clk);
    end while (!(go && !busy));
    items_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write: expected none, got addr %h word %h", $time,
                 out_cfg_address, out_cfg_word);
        err_count++;
      end else begin
        head_write = pending_writes.pop_front();
        check_field("best_mult",   cmds_pkg::WORD_W'(head_write.mult),
                    cmds_pkg::WORD_W'(out_best_mult));
        check_field("best_div",    cmds_pkg::WORD_W'(head_write.div),
                    cmds_pkg::WORD_W'(out_best_div));
        check_field("cfg_address", cmds_pkg::WORD_W'(head_write.addr),
                    cmds_pkg::WORD_W'(out_cfg_address));
        check_field("cfg_word",    head_write.word, out_cfg_word);
        check_field("last_write",  cmds_pkg::WORD_W'(head_write.last),
                    cmds_pkg::WORD_W'(out_last_write));
        writes_seen++;
      end
    end
  end

  initial begin
    logic [cmds_pkg::T_W-1:0] target;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_target_khz = '0;
    target_rows = '{
      // typed: read straight off the ratio
      '{18'd0,      1'b1, 8'd2,   8'd128, 16'h1041, 16'h0000},  // smallest ratio, d of 128, counts of 64 wrap to 0
      '{18'd20000,  1'b1, 8'd2,   8'd1,   16'h1041, 16'h1000},  // first pair exact
      '{18'd10000,  1'b1, 8'd2,   8'd2,   16'h1041, 16'h0041},
      '{18'd5000,   1'b1, 8'd2,   8'd4,   16'h1041, 16'h0082},
      '{18'd15000,  1'b1, 8'd3,   8'd2,   16'h1042, 16'h0041},
      '{18'd200000, 1'b1, 8'd20,  8'd1,   16'h128a, 16'h1000},
      '{18'd256000, 1'b1, 8'd128, 8'd5,   16'h1000, 16'h0083},  // m of 128, counts of 64 wrap to 0
      '{18'd127000, 1'b1, 8'd127, 8'd10,  16'h1fc0, 16'h0145},  // lo count 64
      '{18'd128000, 1'b1, 8'd64,  8'd5,   16'h1820, 16'h0083},
      // predicted
      '{18'd1,      1'b0, 8'd0, 8'd0, 16'h0, 16'h0},
      '{18'h3ffff,  1'b0, 8'd0, 8'd0, 16'h0, 16'h0},  // above range, all ones
      '{18'd200001, 1'b0, 8'd0, 8'd0, 16'h0, 16'h0},
      '{18'd250000, 1'b0, 8'd0, 8'd0, 16'h0, 16'h0},
      '{18'd100,    1'b0, 8'd0, 8'd0, 16'h0, 16'h0},
      '{18'd65535,  1'b0, 8'd0, 8'd0, 16'h0, 16'h0},
      '{18'h20000,  1'b0, 8'd0, 8'd0, 16'h0, 16'h0},
      '{18'h2aaaa,  1'b0, 8'd0, 8'd0, 16'h0, 16'h0},
      '{18'h15555,  1'b0, 8'd0, 8'd0, 16'h0, 16'h0},
      '{18'd25175,  1'b0, 8'd0, 8'd0, 16'h0, 16'h0},
      '{18'd148500, 1'b0, 8'd0, 8'd0, 16'h0, 16'h0},
      '{18'd74250,  1'b0, 8'd0, 8'd0, 16'h0, 16'h0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (target_rows[i]) begin
      send_target(target_rows[i].target);
      if (target_rows[i].typed)
        queue_writes(target_rows[i].mult, target_rows[i].div,
                     target_rows[i].fb_word, target_rows[i].div_word);
      else
        predict_writes(target_rows[i].target);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // a stretch with start held high whenever the core can take it
      gaps_on = !(n >= 30 && n < 50);
      if ($urandom_range(99, 0) < 70)
        target = cmds_pkg::T_W'($urandom_range(200000, 1));
      else
        target = cmds_pkg::T_W'($urandom);
      send_target(target);
      predict_writes(target);
    end
    start <= 1'b0;

    while (pending_writes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d target searches (table rows plus random targets up to the 18-bit max),",
             items_sent);
    $display("checking %0d config writes including count-of-64 encodings.", writes_seen);
    if (err_count == 0 && pending_writes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
